// ===== rtl/core/ests_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ests_pkg - shared types and constants
// Slot layout, event kinds, channel words and the slot table entry format.
// ---------------------------------------------------------------------------
package ests_pkg;

  localparam int OBJECTS     = 16;
  localparam int REACTIONS   = 64;
  localparam int WORKERS     = 64;
  localparam int WORKER_BASE = OBJECTS * REACTIONS;
  localparam int SLOTS       = OBJECTS * REACTIONS + 2 * WORKERS;
  localparam int SLOT_AW     = $clog2(SLOTS);
  localparam int OBJ_AW      = (OBJECTS > 1) ? $clog2(OBJECTS) : 1;

  // event kinds
  localparam logic [3:0] MODE_RX_START    = 4'd0;
  localparam logic [3:0] MODE_RX_END      = 4'd1;
  localparam logic [3:0] MODE_SCHEDULE    = 4'd2;
  localparam logic [3:0] MODE_USER_EVENT  = 4'd3;
  localparam logic [3:0] MODE_USER_VALUE  = 4'd4;
  localparam logic [3:0] MODE_WAIT_START  = 4'd5;
  localparam logic [3:0] MODE_WAIT_END    = 4'd6;
  localparam logic [3:0] MODE_ADV_START   = 4'd7;
  localparam logic [3:0] MODE_ADV_END     = 4'd8;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_START,
    OP_END,
    OP_VALUE
  } op_t;

  typedef struct packed {
    logic [3:0]         mode;
    logic [3:0]         object_index;
    logic [3:0]         trigger_index;
    logic               trigger_valid;
    logic [7:0]         reaction_index;
    logic [7:0]         worker_index;
    logic signed [63:0] event_time;
    logic signed [63:0] user_amount;
  } in_word_t;

  typedef struct packed {
    logic               dropped;
    logic [31:0]        slot_occurrences;
    logic signed [63:0] slot_sum;
    logic signed [63:0] slot_largest;
    logic signed [63:0] slot_smallest;
    logic [31:0]        object_occurrences;
    logic signed [63:0] latest_event_time;
  } out_word_t;

  typedef struct packed {
    logic [63:0] opened_at;
    logic [31:0] count;
    logic [63:0] total;
    logic [63:0] largest;
    logic [63:0] smallest;
  } slot_entry_t;

  // decoded event, carried down the sequencer
  typedef struct packed {
    logic               dropped;
    logic               has_slot;
    logic               has_obj;
    op_t                op;
    logic [OBJ_AW-1:0]  obj;
    logic [SLOT_AW-1:0] slot;
  } ctl_t;

  function automatic logic [31:0] sat_inc32(input logic [31:0] c);
    return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
  endfunction

  function automatic logic signed_gt(input logic [63:0] a, input logic [63:0] b);
    return $signed(a) > $signed(b);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ests_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ests_in_if / ests_out_if - valid/ready channels
// Event words in, statistics words out.
// ---------------------------------------------------------------------------
interface ests_in_if
  import ests_pkg::*;
  ;
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ests_out_if
  import ests_pkg::*;
  ;
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/event_duration_stats_table.sv =====
`default_nettype none
// Flow: a word accepted in IDLE passes through LOOK, DIFF and FOLD, and FOLD
//   loads the output register (later if the previous result is still waiting).
// One word at a time: the slot RAM read, the 64-bit duration subtract and the
//   fold/write-back are done in turn, and no new word is taken until FOLD ends.
// Reset: synchronous, active low. A clearing pass then zeroes all 1152 slot RAM
//   entries, one entry per cycle, with in_ch.ready low.
// ---------------------------------------------------------------------------
// event_duration_stats_table - trace event profiling table
// Keeps per-reaction and per-worker duration statistics in a slot RAM,
// per-object event counts in flops and the latest timestamp seen.
// ---------------------------------------------------------------------------
module event_duration_stats_table
  import ests_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  ests_in_if.sink     in_ch,
  ests_out_if.source  out_ch
);

  // Sequencer: LOOK decodes and reads the slot, DIFF forms the duration,
  // FOLD updates the entry, writes it back and loads the output register.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_DIFF,
    S_FOLD
  } state_t;

  state_t             state_r;
  logic [SLOT_AW-1:0] clr_r;
  in_word_t           item_r;
  ctl_t               ctl_r;
  ctl_t               ctl_nxt;
  logic [63:0]        val_r;
  logic [63:0]        val_nxt;
  logic [63:0]        latest_r;
  logic [31:0]        obj_cnt_r [OBJECTS];
  logic               out_valid_r;
  out_word_t          out_data_r;
  out_word_t          out_nxt;

  slot_entry_t        rd_entry;
  slot_entry_t        upd_entry;
  logic               ram_we;
  logic [SLOT_AW-1:0] ram_waddr;
  slot_entry_t        ram_wdata;
  logic               ram_re;
  logic               fold_fire;
  logic               in_fire;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // FOLD waits until the output register is free
  assign fold_fire = (state_r == S_FOLD) && (!out_valid_r || out_ch.ready);

  // ---- event decode (from the captured word) ----
  always_comb begin
    ctl_nxt          = '0;
    ctl_nxt.op       = OP_NONE;
    unique case (item_r.mode)
      MODE_RX_START, MODE_RX_END, MODE_USER_VALUE: begin
        if (int'(item_r.object_index) >= OBJECTS ||
            (item_r.mode != MODE_USER_VALUE && int'(item_r.reaction_index) >= REACTIONS)) begin
          ctl_nxt.dropped = 1'b1;
        end else begin
          ctl_nxt.has_obj  = 1'b1;
          ctl_nxt.has_slot = 1'b1;
          ctl_nxt.obj      = OBJ_AW'(item_r.object_index);
          // user values live in reaction slot 0 of their object
          ctl_nxt.slot     = SLOT_AW'(int'(item_r.object_index) * REACTIONS +
                             ((item_r.mode == MODE_USER_VALUE) ? 0 :
                              int'(item_r.reaction_index)));
          if (item_r.mode == MODE_RX_START) begin
            ctl_nxt.op = OP_START;
          end else if (item_r.mode == MODE_RX_END) begin
            ctl_nxt.op = OP_END;
          end else begin
            ctl_nxt.op = OP_VALUE;
          end
        end
      end
      MODE_SCHEDULE: begin
        if (!item_r.trigger_valid || int'(item_r.trigger_index) >= OBJECTS) begin
          ctl_nxt.dropped = 1'b1;
        end else begin
          ctl_nxt.has_obj = 1'b1;
          ctl_nxt.obj     = OBJ_AW'(item_r.trigger_index);
        end
      end
      MODE_USER_EVENT: begin
        if (int'(item_r.object_index) >= OBJECTS) begin
          ctl_nxt.dropped = 1'b1;
        end else begin
          ctl_nxt.has_obj = 1'b1;
          ctl_nxt.obj     = OBJ_AW'(item_r.object_index);
        end
      end
      MODE_WAIT_START, MODE_WAIT_END, MODE_ADV_START, MODE_ADV_END: begin
        if (int'(item_r.worker_index) >= WORKERS) begin
          ctl_nxt.dropped = 1'b1;
        end else begin
          // wait slot at 2*w, advance slot at 2*w+1 past the worker base
          ctl_nxt.has_slot = 1'b1;
          ctl_nxt.slot     = SLOT_AW'(WORKER_BASE + 2 * int'(item_r.worker_index) +
                             ((item_r.mode == MODE_ADV_START ||
                               item_r.mode == MODE_ADV_END) ? 1 : 0));
          if (item_r.mode == MODE_WAIT_START || item_r.mode == MODE_ADV_START) begin
            ctl_nxt.op = OP_START;
          end else begin
            ctl_nxt.op = OP_END;
          end
        end
      end
      default: begin
        ctl_nxt.dropped = 1'b1;
      end
    endcase
  end

  // ---- slot RAM ----
  assign ram_re    = (state_r == S_LOOK) && ctl_nxt.has_slot;
  assign ram_we    = (state_r == S_CLEAR) || (fold_fire && ctl_r.has_slot);
  assign ram_waddr = (state_r == S_CLEAR) ? clr_r : ctl_r.slot;
  assign ram_wdata = (state_r == S_CLEAR) ? '0 : upd_entry;

  ests_ram #(
    .WIDTH ($bits(slot_entry_t)),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ctl_nxt.slot),
    .rdata (rd_entry)
  );

  // ---- duration / value select (DIFF) ----
  always_comb begin
    unique case (ctl_r.op)
      OP_END:   val_nxt = item_r.event_time - rd_entry.opened_at;
      OP_VALUE: val_nxt = item_r.user_amount;
      OP_START: val_nxt = item_r.event_time;
      default:  val_nxt = '0;
    endcase
  end

  ests_fold u_fold (
    .cur (rd_entry),
    .op  (ctl_r.op),
    .val (val_r),
    .upd (upd_entry)
  );

  // ---- result word (FOLD) ----
  always_comb begin
    out_nxt                   = '0;
    out_nxt.dropped           = ctl_r.dropped;
    out_nxt.latest_event_time = latest_r;
    if (ctl_r.has_slot) begin
      out_nxt.slot_occurrences = upd_entry.count;
      out_nxt.slot_sum         = upd_entry.total;
      out_nxt.slot_largest     = upd_entry.largest;
      out_nxt.slot_smallest    = upd_entry.smallest;
    end
    if (ctl_r.has_obj) begin
      out_nxt.object_occurrences = sat_inc32(obj_cnt_r[ctl_r.obj]);
    end
  end

  // ---- sequencer, counters and output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      latest_r    <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < OBJECTS; i++) begin
        obj_cnt_r[i] <= '0;
      end
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          if (clr_r == SLOT_AW'(SLOTS - 1)) begin
            state_r <= S_IDLE;
          end else begin
            clr_r <= clr_r + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            item_r  <= in_ch.data;
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          ctl_r <= ctl_nxt;
          // latest time tracks every event, dropped ones too
          if (signed_gt(item_r.event_time, latest_r)) begin
            latest_r <= item_r.event_time;
          end
          state_r <= S_DIFF;
        end
        S_DIFF: begin
          val_r   <= val_nxt;
          state_r <= S_FOLD;
        end
        S_FOLD: begin
          if (fold_fire) begin
            if (ctl_r.has_obj) begin
              obj_cnt_r[ctl_r.obj] <= sat_inc32(obj_cnt_r[ctl_r.obj]);
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase

      if (fold_fire) begin
        out_valid_r <= 1'b1;
        out_data_r  <= out_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ests_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ests_ram - simple dual-port synchronous RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module ests_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ests_fold.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ests_fold - slot entry update
// Start records a time; end/value folds into count, total, max and min, and end clears the start time.
// ---------------------------------------------------------------------------
module ests_fold
  import ests_pkg::*;
(
  input  wire slot_entry_t cur,
  input  wire op_t         op,
  input  wire logic [63:0] val,
  output      slot_entry_t upd
);

  always_comb begin
    upd = cur;
    unique case (op)
      OP_NONE: begin
      end
      OP_START: begin
        upd.opened_at = val;
      end
      OP_END, OP_VALUE: begin
        if (op == OP_END) begin
          upd.opened_at = '0;
        end
        upd.count = sat_inc32(cur.count);
        upd.total = cur.total + val;
        if (signed_gt(val, cur.largest)) begin
          upd.largest = val;
        end
        // zero minimum marks an empty slot
        if (signed_gt(cur.smallest, val) || cur.smallest == '0) begin
          upd.smallest = val;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/ests_checker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ests_checker - port-level checks for the statistics table
// Bound to event_duration_stats_table.
// ---------------------------------------------------------------------------
module ests_checker
  import ests_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // one word in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while previous word in progress");

  // dropped events report no slot and no object statistics
  a_dropped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.dropped |->
      out_data.slot_occurrences == '0 && out_data.slot_sum == '0 &&
      out_data.slot_largest == '0 && out_data.slot_smallest == '0 &&
      out_data.object_occurrences == '0)
    else $error("dropped event carries statistics");

  // a non-empty minimum implies at least one fold
  a_min_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.slot_smallest != '0 |-> out_data.slot_occurrences != '0)
    else $error("slot minimum set with zero count");

  // maximum starts at zero and only grows
  a_max_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_data.slot_largest[63])
    else $error("negative slot maximum");

endmodule

bind event_duration_stats_table ests_checker u_ests_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

`default_nettype wire
